/* src/pef_pkg.sv */
package pef_pkg;

	// Fixed widths of the level, coefficient and channel count fields.
	localparam int LEVEL_W = 24;
	localparam int COEF_W = 24;
	localparam int COUNT_W = 4;

	// Number of sample ports on the frame channel.
	localparam int NUM_PORTS = 8;

	// Parameter defaults.
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int SAMPLE_BITS_DEF = 24;

	// Register reset values.
	localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = 4'd1;
	localparam logic [COEF_W-1:0] DECAY_COEF_RST = 24'd16760439;
	localparam logic [LEVEL_W-1:0] FLOOR_LEVEL_RST = 24'd8389;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LEVEL = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_CMP_MEAN,
		ST_CMP_FLOOR,
		ST_DECAY,
		ST_OUT
	} state_t;

endpackage

/* src/peak_envelope_follower.sv */
// Channel   Direction  Handshake           Payload
// frame     in         in_valid/in_stall   sample_0 .. sample_7
// result    out        out_valid/out_stall peak_out
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// A frame runs through the accumulate, divide, compare and, if taken, decay states; n is the
// clamped channel count. One add/subtract unit does the magnitude sum (one channel a cycle),
// the restoring division by n (one quotient bit a cycle) and both compares; a channel count
// of zero skips straight to the output state.
// in_stall stays high from acceptance until the result enters the output register, which
// waits there while out_stall is high. arst_n clears the held peak and loads the register
// defaults; cfg_ready is always high.
module peak_envelope_follower #(
	parameter int MAX_CHANNELS = pef_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS = pef_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_BITS-1:0]        sample_0,
	input  logic signed [SAMPLE_BITS-1:0]        sample_1,
	input  logic signed [SAMPLE_BITS-1:0]        sample_2,
	input  logic signed [SAMPLE_BITS-1:0]        sample_3,
	input  logic signed [SAMPLE_BITS-1:0]        sample_4,
	input  logic signed [SAMPLE_BITS-1:0]        sample_5,
	input  logic signed [SAMPLE_BITS-1:0]        sample_6,
	input  logic signed [SAMPLE_BITS-1:0]        sample_7,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pef_pkg::LEVEL_W-1:0]          peak_out,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pef_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pef_pkg::LEVEL_W-1:0]          cfg_data
);

	localparam int NP = pef_pkg::NUM_PORTS;
	localparam int LIMIT = (MAX_CHANNELS < NP) ? MAX_CHANNELS : NP;
	localparam int SUM_W = SAMPLE_BITS + $clog2(NP);
	localparam int ALU_W = (SUM_W > pef_pkg::LEVEL_W) ? SUM_W : pef_pkg::LEVEL_W;
	localparam int CNT_W = $clog2(SUM_W + 1);
	localparam int REM_W = pef_pkg::COUNT_W - 1;
	localparam int PROD_W = pef_pkg::LEVEL_W + pef_pkg::COEF_W;

	pef_pkg::state_t state_q, state_d;

	logic [pef_pkg::COUNT_W-1:0] chan_cnt_q;
	logic [pef_pkg::COEF_W-1:0]  decay_q;
	logic [pef_pkg::LEVEL_W-1:0] floor_q;
	logic [pef_pkg::LEVEL_W-1:0] peak_q;
	logic [pef_pkg::LEVEL_W-1:0] peak_out_q;
	logic                        out_valid_q;

	logic [SAMPLE_BITS-1:0]      samp_q [NP];
	logic [SUM_W-1:0]            acc_q;
	logic [REM_W-1:0]            rem_q;
	logic [pef_pkg::COUNT_W-1:0] n_q;
	logic [CNT_W-1:0]            cnt_q;

	logic [pef_pkg::COUNT_W-1:0] eff_n;
	logic [SAMPLE_BITS-1:0]      mag;
	logic [pef_pkg::COUNT_W-1:0] div_t;
	logic [ALU_W-1:0]            alu_a, alu_b;
	logic                        alu_sub;
	logic [ALU_W:0]              alu_res;
	logic                        borrow;
	logic [ALU_W-1:0]            mean_ext;
	logic [PROD_W-1:0]           prod;
	logic                        accept, out_load, cnt_last;

	assign cfg_ready = 1'b1;
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign peak_out = peak_out_q;

	// Channel count clamped to what the block can average.
	assign eff_n = (chan_cnt_q > pef_pkg::COUNT_W'(LIMIT)) ? pef_pkg::COUNT_W'(LIMIT)
		: chan_cnt_q;

	// Magnitude of the sample at the head of the shift line.
	assign mag = samp_q[0][SAMPLE_BITS-1] ? (SAMPLE_BITS'(~samp_q[0]) + SAMPLE_BITS'(1))
		: samp_q[0];

	// Partial remainder with the next dividend bit shifted in.
	assign div_t = {rem_q, acc_q[SUM_W-1]};
	assign mean_ext = ALU_W'(acc_q);
	assign cnt_last = (cnt_q == CNT_W'(1));

	// Shared add/subtract unit: operands chosen by the sequencer state.
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_sub = 1'b0;
		case (state_q)
			pef_pkg::ST_ACC: begin
				alu_a = ALU_W'(acc_q);
				alu_b = ALU_W'(mag);
			end
			pef_pkg::ST_DIV: begin
				alu_a = ALU_W'(div_t);
				alu_b = ALU_W'(n_q);
				alu_sub = 1'b1;
			end
			pef_pkg::ST_CMP_MEAN: begin
				alu_a = ALU_W'(peak_q);
				alu_b = mean_ext;
				alu_sub = 1'b1;
			end
			pef_pkg::ST_CMP_FLOOR: begin
				alu_a = ALU_W'(floor_q);
				alu_b = ALU_W'(peak_q);
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
	assign borrow = alu_res[ALU_W];

	// Release multiply of the held peak by the decay coefficient.
	assign prod = {{pef_pkg::COEF_W{1'b0}}, peak_q} * {{pef_pkg::LEVEL_W{1'b0}}, decay_q};

	// Next state, frame stall and output register load.
	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		case (state_q)
			pef_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = (eff_n == '0) ? pef_pkg::ST_OUT : pef_pkg::ST_ACC;
				end
			end
			pef_pkg::ST_ACC: begin
				if (cnt_last) begin
					state_d = pef_pkg::ST_DIV;
				end
			end
			pef_pkg::ST_DIV: begin
				if (cnt_last) begin
					state_d = pef_pkg::ST_CMP_MEAN;
				end
			end
			pef_pkg::ST_CMP_MEAN: begin
				state_d = borrow ? pef_pkg::ST_OUT : pef_pkg::ST_CMP_FLOOR;
			end
			pef_pkg::ST_CMP_FLOOR: begin
				state_d = borrow ? pef_pkg::ST_DECAY : pef_pkg::ST_OUT;
			end
			pef_pkg::ST_DECAY: begin
				state_d = pef_pkg::ST_OUT;
			end
			pef_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d = pef_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pef_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pef_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= pef_pkg::CHANNEL_COUNT_RST;
			decay_q <= pef_pkg::DECAY_COEF_RST;
			floor_q <= pef_pkg::FLOOR_LEVEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pef_pkg::CFG_CHANNEL_COUNT: chan_cnt_q <= cfg_data[pef_pkg::COUNT_W-1:0];
				pef_pkg::CFG_DECAY_COEF: decay_q <= cfg_data;
				pef_pkg::CFG_FLOOR_LEVEL: floor_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Held peak: jumps to the mean, decays, or clears at or below the floor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else begin
			case (state_q)
				pef_pkg::ST_CMP_MEAN: begin
					if (borrow) begin
						peak_q <= mean_ext[pef_pkg::LEVEL_W-1:0];
					end
				end
				pef_pkg::ST_CMP_FLOOR: begin
					if (!borrow) begin
						peak_q <= '0;
					end
				end
				pef_pkg::ST_DECAY: begin
					peak_q <= prod[PROD_W-1:pef_pkg::COEF_W];
				end
				default: begin
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			peak_out_q <= peak_q;
		end
	end

	// Sample shift line, accumulator/quotient, remainder and step counter.
	always_ff @(posedge clk) begin
		case (state_q)
			pef_pkg::ST_IDLE: begin
				if (accept) begin
					samp_q[0] <= sample_0;
					samp_q[1] <= sample_1;
					samp_q[2] <= sample_2;
					samp_q[3] <= sample_3;
					samp_q[4] <= sample_4;
					samp_q[5] <= sample_5;
					samp_q[6] <= sample_6;
					samp_q[7] <= sample_7;
					acc_q <= '0;
					n_q <= eff_n;
					cnt_q <= CNT_W'(eff_n);
				end
			end
			pef_pkg::ST_ACC: begin
				for (int i = 0; i < NP - 1; i++) begin
					samp_q[i] <= samp_q[i+1];
				end
				acc_q <= alu_res[SUM_W-1:0];
				rem_q <= '0;
				cnt_q <= cnt_last ? CNT_W'(SUM_W) : (cnt_q - CNT_W'(1));
			end
			pef_pkg::ST_DIV: begin
				if (borrow) begin
					rem_q <= div_t[REM_W-1:0];
				end else begin
					rem_q <= alu_res[REM_W-1:0];
				end
				acc_q <= {acc_q[SUM_W-2:0], !borrow};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/pef_checker.sv */
module pef_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic cfg_ready
);

	// A stalled result item stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	// The block is busy in the cycle after it takes a frame item.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("frame item taken while previous one still in work");

	// No result can appear in the cycle right after a frame item is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result item appeared too early");

	// A new result is only issued at the end of a frame's work.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall) && cfg_ready)
		else $error("result item issued while idle");

endmodule

bind peak_envelope_follower pef_checker u_pef_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.cfg_ready(cfg_ready)
);
